### sv/jbh_filt_pkg.sv
// ----------------------------------------------------------------------------
// jbh_filt_pkg
// Shared types, constants and helpers for the jet BIB hypothesis filter.
// ----------------------------------------------------------------------------
`default_nettype none

package jbh_filt_pkg;

  // Item kinds carried on in_tuser
  localparam logic [1:0] FUNC_JET_START = 2'd0;
  localparam logic [1:0] FUNC_TRACK     = 2'd1;
  localparam logic [1:0] FUNC_CELL      = 2'd2;
  localparam logic [1:0] FUNC_JET_END   = 2'd3;

  // Configuration register indexes
  localparam logic [2:0] CFG_EMF_LIMIT   = 3'd0;
  localparam logic [2:0] CFG_TRK_PT_MIN  = 3'd1;
  localparam logic [2:0] CFG_TRK_DR2_LIM = 3'd2;
  localparam logic [2:0] CFG_BIB_ENABLE  = 3'd3;
  localparam logic [2:0] CFG_CELL_E_MIN  = 3'd4;
  localparam logic [2:0] CFG_CELL_T_MAX  = 3'd5;
  localparam logic [2:0] CFG_BIB_T_WIN   = 3'd6;
  localparam logic [2:0] CFG_CNT_LIMIT   = 3'd7;

  // Reject reasons
  localparam logic [2:0] RSN_NONE  = 3'd0;
  localparam logic [2:0] RSN_PREV  = 3'd1;
  localparam logic [2:0] RSN_EMF   = 3'd2;
  localparam logic [2:0] RSN_TRACK = 3'd3;
  localparam logic [2:0] RSN_BIB   = 3'd4;

  // Layer counter width
  localparam int COUNT_BITS = 16;

  // Fixed-point constants
  localparam logic signed [17:0] PHI_PI        = 18'sd12868;
  localparam logic signed [17:0] PHI_TWO_PI    = 18'sd25736;
  localparam logic [16:0]        CELL_DPHI_MAX = 17'd819;
  localparam logic [33:0]        CELL_DR2_MIN  = 34'd2684354;
  localparam logic [29:0]        R2_LAYER1     = 30'd4840000;   // 2200 mm squared
  localparam logic [29:0]        R2_LAYER2     = 30'd6760000;   // 2600 mm squared
  localparam logic [29:0]        R2_LAYER3     = 30'd9610000;   // 3100 mm squared
  localparam logic signed [29:0] C_LIGHT_UM    = 30'sd299792458; // m/s
  localparam logic signed [29:0] K_16E6_RED    = 30'sd15625;     // 16e6 / 1024
  localparam int                 SQRT_STEPS    = 24;

  // Main sequencer states
  typedef enum logic [3:0] {
    ST_IDLE, ST_DE2, ST_DP2, ST_DR, ST_X2, ST_Y2, ST_Z2, ST_SQ0, ST_SQ,
    ST_TC, ST_LIM, ST_VA, ST_VB, ST_VC, ST_FIN
  } jbh_state_t;

  // Wrap a phi difference into [-pi, pi], two correction steps at most
  function automatic logic signed [16:0] wrap_phi(input logic signed [16:0] d_in);
    logic signed [17:0] d;
    d = {d_in[16], d_in};
    for (int k = 0; k < 2; k++) begin
      if (d > PHI_PI) d = d - PHI_TWO_PI;
      else if (d < -PHI_PI) d = d + PHI_TWO_PI;
    end
    return d[16:0];
  endfunction

endpackage

`default_nettype wire

### sv/jet_bib_hypothesis_filter_top.sv
// ----------------------------------------------------------------------------
// jet_bib_hypothesis_filter_top
// Jet filter: EMF, track isolation and beam-induced background cell cuts.
// ----------------------------------------------------------------------------
// Jet-start, end and cell items that fail the cheap gates are finished when
// taken. A track, or a cell inside the dR cone, takes two squares on the
// shared multiplier plus the compare. A cell that passes all gates takes five
// squares, a 24-step bit-serial square root that holds the sequencer, then
// four more products and compares for the BIB time test, all on one
// registered multiplier. in_tready is low meanwhile.
// While a result waits in the output register, items other than an end of jet
// are still taken; an end of jet waits until the result transfer.
`default_nettype none

module jet_bib_hypothesis_filter_top (
  input  wire logic         clk,
  input  wire logic         rst_n,
  // tdata: eta[15:0] phi[30:16] emf[46:31] prev_passed[47] track_pt[71:48]
  //        cell_is_tile[72] cell_energy[96:73] cell_time[112:97]
  //        cell_x[127:113] cell_y[142:128] cell_z[157:143], zero pad
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [159:0] in_tdata,
  input  wire logic [1:0]   in_tuser,   // func
  // tdata: jet_accepted[0] reject_reason[3:1] busiest_layer_count[19:4], pad
  output logic              out_tvalid,
  input  wire logic         out_tready,
  output logic [23:0]       out_tdata,
  input  wire logic         cfg_wr_en,
  input  wire logic [2:0]   cfg_addr,
  input  wire logic [23:0]  cfg_wdata
);

  import jbh_filt_pkg::*;

  // Configuration
  logic [14:0]        emf_limit_r;
  logic [23:0]        trk_pt_min_r;
  logic [23:0]        trk_dr2_lim_r;
  logic               bib_en_r;
  logic [22:0]        cell_e_min_r;
  logic signed [15:0] cell_t_max_r;
  logic [14:0]        bib_t_win_r;
  logic [15:0]        cnt_limit_r;

  // Jet state
  logic signed [15:0] jet_eta_r;
  logic signed [14:0] jet_phi_r;
  logic [2:0]         early_rsn_r;
  logic               trk_veto_r;
  logic [COUNT_BITS-1:0] layer_cnt_r [4];

  // Held item
  logic               is_cell_r;
  logic signed [15:0] eta_r;
  logic signed [14:0] phi_r;
  logic [23:0]        pt_r;
  logic signed [15:0] t_r;
  logic signed [14:0] x_r, y_r, z_r;

  // Sequencer and datapath
  jbh_state_t         state_r, state_nxt;
  logic [33:0]        acc_r;
  logic [29:0]        r2_r;
  logic signed [44:0] tc_r;
  logic [43:0]        lim_r;
  logic signed [56:0] diff_r;
  logic               fit_r;

  logic               out_valid_r;
  logic [23:0]        out_data_r;

  // Input fields
  logic signed [15:0] in_eta, in_emf, in_t;
  logic signed [14:0] in_phi, in_x, in_y, in_z;
  logic               in_prev, in_tile;
  logic [23:0]        in_pt;
  logic signed [23:0] in_e;
  logic               in_acc;

  assign in_eta  = in_tdata[15:0];
  assign in_phi  = in_tdata[30:16];
  assign in_emf  = in_tdata[46:31];
  assign in_prev = in_tdata[47];
  assign in_pt   = in_tdata[71:48];
  assign in_tile = in_tdata[72];
  assign in_e    = in_tdata[96:73];
  assign in_t    = in_tdata[112:97];
  assign in_x    = in_tdata[127:113];
  assign in_y    = in_tdata[142:128];
  assign in_z    = in_tdata[157:143];

  // Only an end of jet needs the output register free
  assign in_tready = (state_r == ST_IDLE) &&
                     (!out_valid_r || out_tready || in_tuser != FUNC_JET_END);
  assign in_acc    = in_tvalid && in_tready;

  // Cheap cell gates evaluated on the incoming item
  logic signed [16:0] in_dp;
  logic [16:0]        in_dp_abs;
  logic               cell_go;

  assign in_dp     = wrap_phi(17'(in_phi) - 17'(jet_phi_r));
  assign in_dp_abs = in_dp[16] ? 17'(-in_dp) : in_dp;
  assign cell_go   = bib_en_r && in_tile &&
                     (25'(in_e) > $signed({2'b00, cell_e_min_r})) &&
                     (in_dp_abs <= CELL_DPHI_MAX) && (in_t < cell_t_max_r);

  // Shared units
  logic signed [25:0] mul_a;
  logic signed [29:0] mul_b;
  logic signed [55:0] prod;
  logic               sq_start, sq_busy;
  logic [23:0]        sq_root;

  jbh_filt_mul u_mul (
    .clk    (clk),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod)
  );

  jbh_filt_sqrt u_sqrt (
    .clk        (clk),
    .rst_n      (rst_n),
    .start_i    (sq_start),
    .radicand_i ({1'b0, 31'(acc_r + prod[33:0]), 16'd0}),
    .busy_o     (sq_busy),
    .root_o     (sq_root)
  );

  // Operand values
  logic signed [16:0] de, dp;
  logic signed [22:0] zs;
  logic signed [25:0] va, vb;
  logic [33:0]        dr2;
  logic signed [56:0] tc_sh, vp_sh;
  logic [56:0]        diff_abs;
  logic [56:0]        lim_sh;
  logic               fit_now;

  assign de       = 17'(eta_r) - 17'(jet_eta_r);
  assign dp       = wrap_phi(17'(phi_r) - 17'(jet_phi_r));
  assign zs       = {z_r, 8'd0};
  assign va       = 26'(zs) - $signed({2'b00, sq_root});
  assign vb       = -26'(zs) - $signed({2'b00, sq_root});
  assign dr2      = acc_r + prod[33:0];
  assign tc_sh    = {{4{tc_r[44]}}, tc_r, 8'd0};  // t * c * 256
  assign vp_sh    = {prod[46:0], 10'd0};          // v * 16e6
  assign diff_abs = diff_r[56] ? 57'(-diff_r) : diff_r;
  assign lim_sh   = {5'd0, lim_r, 8'd0};
  assign fit_now  = diff_abs < lim_sh;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc && in_tuser == FUNC_TRACK) state_nxt = ST_DE2;
        else if (in_acc && in_tuser == FUNC_CELL && cell_go) state_nxt = ST_DE2;
      end
      ST_DE2: state_nxt = ST_DP2;
      ST_DP2: state_nxt = ST_DR;
      ST_DR:  state_nxt = (is_cell_r && dr2 > CELL_DR2_MIN) ? ST_X2 : ST_IDLE;
      ST_X2:  state_nxt = ST_Y2;
      ST_Y2:  state_nxt = ST_Z2;
      ST_Z2:  state_nxt = ST_SQ0;
      ST_SQ0: state_nxt = ST_SQ;
      ST_SQ:  state_nxt = sq_busy ? ST_SQ : ST_TC;
      ST_TC:  state_nxt = ST_LIM;
      ST_LIM: state_nxt = ST_VA;
      ST_VA:  state_nxt = ST_VB;
      ST_VB:  state_nxt = ST_VC;
      ST_VC:  state_nxt = ST_FIN;
      ST_FIN: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Sequencer outputs: multiplier operands and root start
  always_comb begin
    mul_a    = '0;
    mul_b    = '0;
    sq_start = 1'b0;
    case (state_r)
      ST_DE2: begin mul_a = 26'(de);  mul_b = 30'(de);  end
      ST_DP2: begin mul_a = 26'(dp);  mul_b = 30'(dp);  end
      ST_X2:  begin mul_a = 26'(x_r); mul_b = 30'(x_r); end
      ST_Y2:  begin mul_a = 26'(y_r); mul_b = 30'(y_r); end
      ST_Z2:  begin mul_a = 26'(z_r); mul_b = 30'(z_r); end
      ST_SQ0: sq_start = 1'b1;
      ST_TC:  begin mul_a = 26'(t_r); mul_b = C_LIGHT_UM; end
      ST_LIM: begin mul_a = $signed({11'd0, bib_t_win_r}); mul_b = C_LIGHT_UM; end
      ST_VA:  begin mul_a = va; mul_b = K_16E6_RED; end
      ST_VB:  begin mul_a = vb; mul_b = K_16E6_RED; end
      default: begin end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      emf_limit_r   <= 15'd1491;
      trk_pt_min_r  <= 24'd2000;
      trk_dr2_lim_r <= 24'd134218;
      bib_en_r      <= 1'b1;
      cell_e_min_r  <= 23'd240;
      cell_t_max_r  <= -16'sd32;
      bib_t_win_r   <= 15'd80;
      cnt_limit_r   <= 16'd4;
    end else if (cfg_wr_en) begin
      case (cfg_addr)
        CFG_EMF_LIMIT:   emf_limit_r   <= cfg_wdata[14:0];
        CFG_TRK_PT_MIN:  trk_pt_min_r  <= cfg_wdata;
        CFG_TRK_DR2_LIM: trk_dr2_lim_r <= cfg_wdata;
        CFG_BIB_ENABLE:  bib_en_r      <= cfg_wdata[0];
        CFG_CELL_E_MIN:  cell_e_min_r  <= cfg_wdata[22:0];
        CFG_CELL_T_MAX:  cell_t_max_r  <= cfg_wdata[15:0];
        CFG_BIB_T_WIN:   bib_t_win_r   <= cfg_wdata[14:0];
        CFG_CNT_LIMIT:   cnt_limit_r   <= cfg_wdata[15:0];
        default: begin end
      endcase
    end
  end

  // Busiest layer and verdict
  logic [COUNT_BITS-1:0] max01, max23, best;
  logic [15:0]           best_sat;
  logic [2:0]            reason;

  assign max01    = (layer_cnt_r[1] > layer_cnt_r[0]) ? layer_cnt_r[1] : layer_cnt_r[0];
  assign max23    = (layer_cnt_r[3] > layer_cnt_r[2]) ? layer_cnt_r[3] : layer_cnt_r[2];
  assign best     = (max23 > max01) ? max23 : max01;
  assign best_sat = (33'(best) > 33'd65535) ? 16'hFFFF : 16'(best);

  always_comb begin
    if (early_rsn_r != RSN_NONE) reason = early_rsn_r;
    else if (trk_veto_r) reason = RSN_TRACK;
    else if (bib_en_r && 33'(best) >= 33'(cnt_limit_r)) reason = RSN_BIB;
    else reason = RSN_NONE;
  end

  // Layer index from r^2
  logic [1:0] layer;
  always_comb begin
    if (r2_r < R2_LAYER1)      layer = 2'd0;
    else if (r2_r < R2_LAYER2) layer = 2'd1;
    else if (r2_r < R2_LAYER3) layer = 2'd2;
    else                       layer = 2'd3;
  end

  // Jet state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      jet_eta_r   <= '0;
      jet_phi_r   <= '0;
      early_rsn_r <= RSN_NONE;
      trk_veto_r  <= 1'b0;
      for (int i = 0; i < 4; i++) layer_cnt_r[i] <= '0;
    end else if (in_acc && in_tuser == FUNC_JET_START) begin
      jet_eta_r <= in_eta;
      jet_phi_r <= in_phi;
      if (!in_prev) early_rsn_r <= RSN_PREV;
      else if (in_emf > 16'sd0 &&
               (in_emf >= 16'sd16384 || 17'(in_emf) > $signed({2'b00, emf_limit_r})))
        early_rsn_r <= RSN_EMF;
      else early_rsn_r <= RSN_NONE;
      trk_veto_r <= 1'b0;
      for (int i = 0; i < 4; i++) layer_cnt_r[i] <= '0;
    end else if (state_r == ST_DR && !is_cell_r) begin
      if (pt_r >= trk_pt_min_r && dr2 < 34'(trk_dr2_lim_r)) trk_veto_r <= 1'b1;
    end else if (state_r == ST_FIN && (fit_r || fit_now)) begin
      if (layer_cnt_r[layer] != {COUNT_BITS{1'b1}})
        layer_cnt_r[layer] <= layer_cnt_r[layer] + 1'b1;
    end
  end

  // Item capture and arithmetic registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      is_cell_r <= (in_tuser == FUNC_CELL);
      eta_r     <= in_eta;
      phi_r     <= in_phi;
      pt_r      <= in_pt;
      t_r       <= in_t;
      x_r       <= in_x;
      y_r       <= in_y;
      z_r       <= in_z;
    end
    case (state_r)
      ST_DP2: acc_r  <= prod[33:0];
      ST_Y2:  acc_r  <= prod[33:0];
      ST_Z2:  acc_r  <= acc_r + prod[33:0];
      ST_SQ0: r2_r   <= acc_r[29:0];
      ST_LIM: tc_r   <= prod[44:0];
      ST_VA:  lim_r  <= prod[43:0];
      ST_VB:  diff_r <= tc_sh - vp_sh;
      ST_VC: begin
        fit_r  <= fit_now;
        diff_r <= tc_sh - vp_sh;
      end
      default: begin end
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_acc && in_tuser == FUNC_JET_END) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && in_tuser == FUNC_JET_END)
      out_data_r <= {4'd0, best_sat, reason, reason == RSN_NONE};
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

`default_nettype wire

### sv/jbh_filt_mul.sv
// ----------------------------------------------------------------------------
// jbh_filt_mul
// Shared signed multiplier with a registered product.
// ----------------------------------------------------------------------------
`default_nettype none

module jbh_filt_mul (
  input  wire logic               clk,
  input  wire logic signed [25:0] a_i,
  input  wire logic signed [29:0] b_i,
  output logic signed [55:0]      prod_o
);

  logic signed [55:0] prod_r;

  // One product per cycle
  always_ff @(posedge clk) begin
    prod_r <= 56'(a_i) * 56'(b_i);
  end

  assign prod_o = prod_r;

endmodule

`default_nettype wire

### sv/jbh_filt_sqrt.sv
// ----------------------------------------------------------------------------
// jbh_filt_sqrt
// Bit-serial integer square root, one result bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module jbh_filt_sqrt (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start_i,
  input  wire logic [47:0] radicand_i,
  output logic             busy_o,
  output logic [23:0]      root_o
);

  import jbh_filt_pkg::*;

  logic [47:0] rad_r;
  logic [25:0] rem_r;
  logic [23:0] root_r;
  logic [4:0]  cnt_r;
  logic [25:0] rem_sh;
  logic [25:0] trial;

  // Restoring step
  assign rem_sh = {rem_r[23:0], rad_r[47:46]};
  assign trial  = {root_r, 2'b01};

  // Step counter is control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (start_i) begin
      cnt_r <= 5'(SQRT_STEPS);
    end else if (cnt_r != '0) begin
      cnt_r <= cnt_r - 5'd1;
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (start_i) begin
      rad_r  <= radicand_i;
      rem_r  <= '0;
      root_r <= '0;
    end else if (cnt_r != '0) begin
      rad_r <= {rad_r[45:0], 2'b00};
      if (rem_sh >= trial) begin
        rem_r  <= rem_sh - trial;
        root_r <= {root_r[22:0], 1'b1};
      end else begin
        rem_r  <= rem_sh;
        root_r <= {root_r[22:0], 1'b0};
      end
    end
  end

  assign busy_o = (cnt_r != '0);
  assign root_o = root_r;

endmodule

`default_nettype wire

### sv/jbh_filt_checker.sv
// ----------------------------------------------------------------------------
// jbh_filt_checker
// Port-level checks for the jet BIB hypothesis filter.
// ----------------------------------------------------------------------------
`default_nettype none

module jbh_filt_checker (
  input wire logic         clk,
  input wire logic         rst_n,
  input wire logic         in_tvalid,
  input wire logic         in_tready,
  input wire logic [1:0]   in_tuser,
  input wire logic         out_tvalid,
  input wire logic         out_tready,
  input wire logic [23:0]  out_tdata
);

  import jbh_filt_pkg::*;

  // A pending result is held until the transfer
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // Accepted flag agrees with the reason code
  a_acc_rsn: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[0] == (out_tdata[3:1] == RSN_NONE)))
    else $error("accept flag and reason disagree");

  // Reason code in range
  a_rsn_rng: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[3:1] <= RSN_BIB))
    else $error("bad reason code");

  // An end-of-jet transfer produces a result next cycle
  a_end_res: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tuser == FUNC_JET_END |=> out_tvalid)
    else $error("missing result after end of jet");

endmodule

bind jet_bib_hypothesis_filter_top jbh_filt_checker u_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

`default_nettype wire
